// File: hdl/page_framebuffer_column_blit_defines.svh
// ----------------------------------------------------------------------------
// page_framebuffer_column_blit_defines.svh
// Assertion macros shared by the column blit RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_COLUMN_BLIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_COLUMN_BLIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PFCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfcb assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PFCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfcb assertion failed");

`endif

// File: hdl/pfcb_pkg.sv
// ----------------------------------------------------------------------------
// pfcb_pkg
// Codes, state encoding and controller/datapath bundles of the column blit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcb_pkg;

  // Item command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Draw mode codes
  localparam logic [1:0] MODE_OPAQUE  = 2'd0;
  localparam logic [1:0] MODE_ERASE   = 2'd1;
  localparam logic [1:0] MODE_OVERLAY = 2'd2;

  // Bit order code: bit 7 of the glyph column is the top pixel
  localparam logic BIT_ORDER_MSB_TOP = 1'b1;

  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    KIND_DRAW,
    KIND_READ,
    KIND_CLEAR,
    KIND_NOP
  } item_kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_RD0,
    ST_WR0,
    ST_WR1,
    ST_RDREQ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RSEL_PAGE0,
    RSEL_PAGE1,
    RSEL_READ
  } rd_sel_t;

  typedef enum logic [1:0] {
    WSEL_PAGE0,
    WSEL_PAGE1,
    WSEL_CLEAR
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_req;
    wr_sel_t wr_sel;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_t in_kind;
    logic       cnt_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/pfcb_if.sv
// ----------------------------------------------------------------------------
// pfcb_if
// Valid/ready channels for draw/read/clear items and their result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfcb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] column_x;
  logic [7:0] top_row;
  logic [7:0] column_bits;
  logic       bit_order;
  logic [1:0] draw_mode;
  logic [9:0] read_address;

  modport source (
    output valid, command, column_x, top_row, column_bits, bit_order, draw_mode,
           read_address,
    input  ready
  );
  modport sink (
    input  valid, command, column_x, top_row, column_bits, bit_order, draw_mode,
           read_address,
    output ready
  );
endinterface

interface pfcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       clipped;

  modport source (output valid, read_data, clipped, input ready);
  modport sink (input valid, read_data, clipped, output ready);
endinterface

`default_nettype wire

// File: hdl/pfcb_ram.sv
// ----------------------------------------------------------------------------
// pfcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 480,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/pfcb_ctrl.sv
// ----------------------------------------------------------------------------
// pfcb_ctrl
// Sequencer: store sweep, read-modify-write of two page bytes, byte read, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pfcb_pkg::dp_status_t status,
  output pfcb_pkg::dp_cmd_t         cmd
);

  pfcb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfcb_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pfcb_pkg::ST_INIT, pfcb_pkg::ST_CLR: begin
        cmd.wr_req = 1'b1;
        cmd.wr_sel = pfcb_pkg::WSEL_CLEAR;
        if (status.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = (state_r == pfcb_pkg::ST_INIT) ? pfcb_pkg::ST_IDLE
                                                       : pfcb_pkg::ST_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      pfcb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (status.in_kind)
            pfcb_pkg::KIND_DRAW:  state_nxt = pfcb_pkg::ST_RD0;
            pfcb_pkg::KIND_READ:  state_nxt = pfcb_pkg::ST_RDREQ;
            pfcb_pkg::KIND_CLEAR: state_nxt = pfcb_pkg::ST_CLR;
            default:              state_nxt = pfcb_pkg::ST_DONE;
          endcase
        end
      end
      pfcb_pkg::ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pfcb_pkg::RSEL_PAGE0;
        state_nxt  = pfcb_pkg::ST_WR0;
      end
      pfcb_pkg::ST_WR0: begin
        // write back the upper page byte while fetching the lower one
        cmd.wr_req = 1'b1;
        cmd.wr_sel = pfcb_pkg::WSEL_PAGE0;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pfcb_pkg::RSEL_PAGE1;
        state_nxt  = pfcb_pkg::ST_WR1;
      end
      pfcb_pkg::ST_WR1: begin
        cmd.wr_req = 1'b1;
        cmd.wr_sel = pfcb_pkg::WSEL_PAGE1;
        state_nxt  = pfcb_pkg::ST_DONE;
      end
      pfcb_pkg::ST_RDREQ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pfcb_pkg::RSEL_READ;
        state_nxt  = pfcb_pkg::ST_DONE;
      end
      pfcb_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = pfcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfcb_pkg::ST_IDLE;
      end
    endcase
  end

  // Result beat valid: set on load, drop when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hdl/pfcb_dp.sv
// ----------------------------------------------------------------------------
// pfcb_dp
// Item registers, page address and mask generation, byte merge, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcb_dp #(
  parameter int unsigned COLUMNS = 96,
  parameter int unsigned PAGES   = 5,
  parameter int unsigned DEPTH   = COLUMNS * PAGES,
  parameter int unsigned AW      = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           in_command,
  input  wire logic [7:0]           in_column_x,
  input  wire logic [7:0]           in_top_row,
  input  wire logic [7:0]           in_column_bits,
  input  wire logic                 in_bit_order,
  input  wire logic [1:0]           in_draw_mode,
  input  wire logic [9:0]           in_read_address,
  input  wire pfcb_pkg::dp_cmd_t    cmd,
  output pfcb_pkg::dp_status_t      status,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [7:0]                mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  wire logic [7:0]           mem_rdata,
  output logic [7:0]                out_read_data,
  output logic                      out_clipped
);

  localparam int unsigned ROWS = 8 * PAGES;
  localparam logic [8:0]  COLS_LIM  = 9'(COLUMNS);
  localparam logic [5:0]  PAGES_LIM = 6'(PAGES);
  localparam logic [8:0]  ROWS_LIM  = 9'(ROWS);
  localparam logic [10:0] DEPTH_LIM = 11'(DEPTH);
  localparam logic [13:0] COLS_MUL  = 14'(COLUMNS);
  localparam logic [AW-1:0] CNT_LAST = AW'(DEPTH - 1);

  pfcb_pkg::item_kind_t kind_r, in_kind;
  logic [7:0]           x_r, top_r, bits_r;
  logic                 order_r;
  logic [1:0]           mode_r;
  logic [9:0]           addr_r;
  logic [AW-1:0]        cnt_r;
  logic [7:0]           read_data_r;
  logic                 clipped_r;

  logic [7:0]  lit;
  logic [2:0]  sh;
  logic [15:0] mask_w, lit_w;
  logic [4:0]  page0;
  logic [5:0]  page1;
  logic        x_ok, lo_ok, hi_ok, row_clip, draw_clip, read_ok;
  logic [13:0] addr0_full, addr1_full;
  logic [AW-1:0] addr0, addr1, raddr_rd;

  function automatic logic [7:0] merge_byte(input logic [7:0] old, input logic [7:0] m,
                                            input logic [7:0] l, input logic [1:0] mode);
    logic [7:0] res;
    res = old;
    case (mode)
      pfcb_pkg::MODE_ERASE:   res = old & ~m;
      pfcb_pkg::MODE_OPAQUE:  res = (old & ~m) | (l & m);
      pfcb_pkg::MODE_OVERLAY: res = old | (l & m);
      default:                res = old;
    endcase
    return res;
  endfunction

  // Classify the offered item
  always_comb begin
    case (in_command)
      pfcb_pkg::CMD_DRAW: begin
        if (in_draw_mode == pfcb_pkg::MODE_OPAQUE || in_draw_mode == pfcb_pkg::MODE_ERASE ||
            in_draw_mode == pfcb_pkg::MODE_OVERLAY) begin
          in_kind = pfcb_pkg::KIND_DRAW;
        end else begin
          in_kind = pfcb_pkg::KIND_NOP;
        end
      end
      pfcb_pkg::CMD_READ:  in_kind = pfcb_pkg::KIND_READ;
      pfcb_pkg::CMD_CLEAR: in_kind = pfcb_pkg::KIND_CLEAR;
      default:             in_kind = pfcb_pkg::KIND_NOP;
    endcase
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      x_r     <= in_column_x;
      top_r   <= in_top_row;
      bits_r  <= in_column_bits;
      order_r <= in_bit_order;
      mode_r  <= in_draw_mode;
      addr_r  <= in_read_address;
    end
  end

  // Sweep counter for store clears
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.in_kind  = in_kind;
  assign status.cnt_last = (cnt_r == CNT_LAST);

  // Put the top pixel in bit 0
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lit[i] = (order_r == pfcb_pkg::BIT_ORDER_MSB_TOP) ? bits_r[7 - i] : bits_r[i];
    end
  end

  // Spread the column over the two page bytes it can touch
  assign sh     = top_r[2:0];
  assign mask_w = 16'h00FF << sh;
  assign lit_w  = {8'h00, lit} << sh;
  assign page0  = top_r[7:3];
  assign page1  = {1'b0, page0} + 6'd1;

  assign x_ok      = ({1'b0, x_r} < COLS_LIM);
  assign lo_ok     = x_ok && ({1'b0, page0} < PAGES_LIM);
  assign hi_ok     = x_ok && (sh != 3'd0) && (page1 < PAGES_LIM);
  assign row_clip  = (({1'b0, top_r} + 9'd7) >= ROWS_LIM);
  assign draw_clip = !x_ok || row_clip;
  assign read_ok   = ({1'b0, addr_r} < DEPTH_LIM);

  // Byte addresses: page * COLUMNS + column
  assign addr0_full = 14'(page0) * COLS_MUL + 14'(x_r);
  assign addr1_full = 14'(page1) * COLS_MUL + 14'(x_r);
  assign addr0      = lo_ok   ? addr0_full[AW-1:0] : '0;
  assign addr1      = hi_ok   ? addr1_full[AW-1:0] : '0;
  assign raddr_rd   = read_ok ? AW'(addr_r) : '0;

  // Memory read port
  always_comb begin
    case (cmd.rd_sel)
      pfcb_pkg::RSEL_PAGE0: begin
        mem_raddr = addr0;
        mem_re    = cmd.rd_en && lo_ok;
      end
      pfcb_pkg::RSEL_PAGE1: begin
        mem_raddr = addr1;
        mem_re    = cmd.rd_en && hi_ok;
      end
      pfcb_pkg::RSEL_READ: begin
        mem_raddr = raddr_rd;
        mem_re    = cmd.rd_en && read_ok;
      end
      default: begin
        mem_raddr = '0;
        mem_re    = 1'b0;
      end
    endcase
  end

  // Memory write port: merged page bytes or sweep zeros
  always_comb begin
    case (cmd.wr_sel)
      pfcb_pkg::WSEL_PAGE0: begin
        mem_waddr = addr0;
        mem_wdata = merge_byte(mem_rdata, mask_w[7:0], lit_w[7:0], mode_r);
        mem_we    = cmd.wr_req && lo_ok;
      end
      pfcb_pkg::WSEL_PAGE1: begin
        mem_waddr = addr1;
        mem_wdata = merge_byte(mem_rdata, mask_w[15:8], lit_w[15:8], mode_r);
        mem_we    = cmd.wr_req && hi_ok;
      end
      pfcb_pkg::WSEL_CLEAR: begin
        mem_waddr = cnt_r;
        mem_wdata = '0;
        mem_we    = cmd.wr_req;
      end
      default: begin
        mem_waddr = '0;
        mem_wdata = '0;
        mem_we    = 1'b0;
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data_r <= (kind_r == pfcb_pkg::KIND_READ && read_ok) ? mem_rdata : 8'h00;
      case (kind_r)
        pfcb_pkg::KIND_DRAW: clipped_r <= draw_clip;
        pfcb_pkg::KIND_READ: clipped_r <= !read_ok;
        default:             clipped_r <= 1'b0;
      endcase
    end
  end

  assign out_read_data = read_data_r;
  assign out_clipped   = clipped_r;

endmodule

`default_nettype wire

// File: hdl/page_framebuffer_column_blit.sv
// Sequence: a draw steps through RD0, WR0, WR1 and DONE, a read through RDREQ and DONE,
//   an unused code straight to DONE, a clear through a sweep (one byte per cycle) and DONE.
// Items: one at a time; the next is taken after DONE loads the result beat. The draw steps
//   come from the single RAM write and read port (two page bytes read-modify-write).
// Reset: synchronous active-low; afterwards the RAM is zeroed one byte per cycle
//   over all COLUMNS*PAGES bytes (480 at default), during which no item is accepted.
// ----------------------------------------------------------------------------
// page_framebuffer_column_blit
// Monochrome page framebuffer with 8-pixel vertical column draw, byte read
// and whole-store clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_framebuffer_column_blit_defines.svh"

module page_framebuffer_column_blit #(
  parameter int unsigned COLUMNS = 96,
  parameter int unsigned PAGES   = 5
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pfcb_in_if.sink     in_ch,
  pfcb_out_if.source  out_ch
);

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);

  pfcb_pkg::dp_cmd_t    dp_cmd;
  pfcb_pkg::dp_status_t dp_status;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata, mem_rdata;
  logic                 sweep_wr;

  // Sequencer
  pfcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Datapath
  pfcb_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_ch.command),
    .in_column_x     (in_ch.column_x),
    .in_top_row      (in_ch.top_row),
    .in_column_bits  (in_ch.column_bits),
    .in_bit_order    (in_ch.bit_order),
    .in_draw_mode    (in_ch.draw_mode),
    .in_read_address (in_ch.read_address),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .out_read_data   (out_ch.read_data),
    .out_clipped     (out_ch.clipped)
  );

  // Frame store
  pfcb_ram #(
    .WIDTH (pfcb_pkg::BYTE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Flag sweep writes
  assign sweep_wr = dp_cmd.wr_req && (dp_cmd.wr_sel == pfcb_pkg::WSEL_CLEAR);

  // No beat is taken while the store is being swept
  `PFCB_ASSERT_IMP(a_no_accept_in_sweep, clk, rst_n, sweep_wr, !in_ch.ready)
  // One item at a time
  `PFCB_ASSERT_NEXT(a_one_item, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // A waiting result beat is never overwritten
  `PFCB_ASSERT_IMP(a_out_no_overwrite, clk, rst_n, dp_cmd.out_load, !out_ch.valid || out_ch.ready)
  // Read-modify-write never reads the byte it writes in the same cycle
  `PFCB_ASSERT_IMP(a_rmw_no_collide, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives draw, read and clear items into the page framebuffer column blit and
// checks every result beat against a behavioral copy of the frame store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FB_COLUMNS = 96;
  localparam int unsigned FB_PAGES   = 5;
  localparam int unsigned FB_BYTES   = FB_COLUMNS * FB_PAGES;
  localparam int unsigned FB_ROWS    = FB_PAGES * 8;

  // Codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic BIT_ORDER_LSB_TOP = 1'b0;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] column_x;
    logic [7:0] top_row;
    logic [7:0] column_bits;
    logic       bit_order;
    logic [1:0] draw_mode;
    logic [9:0] read_address;
  } blit_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } blit_result_t;

  // Frame store copy plus the queue of results still owed by the block
  class frame_scoreboard;
    logic [7:0]   frame_bytes [FB_BYTES];
    blit_result_t owed_results[$];
    int unsigned  mismatches;
    int unsigned  draws, reads, clears, unused, clipped_beats;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    endfunction

    // Apply one item to the frame copy and return the beat it must produce
    function blit_result_t render_item(blit_item_t it);
      blit_result_t res;
      int unsigned  row;
      int unsigned  idx;
      logic         lit;
      res = '0;
      case (it.command)
        pfcb_pkg::CMD_DRAW: begin
          draws++;
          if (it.draw_mode != MODE_UNUSED) begin
            for (int i = 0; i < 8; i++) begin
              lit = (it.bit_order == pfcb_pkg::BIT_ORDER_MSB_TOP) ? it.column_bits[7 - i]
                                                                   : it.column_bits[i];
              row = int'(it.top_row) + i;
              if (it.column_x >= FB_COLUMNS || row >= FB_ROWS) begin
                res.clipped = 1'b1;
              end else begin
                idx = (row / 8) * FB_COLUMNS + it.column_x;
                if (it.draw_mode == pfcb_pkg::MODE_ERASE ||
                    (it.draw_mode == pfcb_pkg::MODE_OPAQUE && !lit))
                  frame_bytes[idx][row % 8] = 1'b0;
                else if (lit)
                  frame_bytes[idx][row % 8] = 1'b1;
              end
            end
          end
        end
        pfcb_pkg::CMD_READ: begin
          reads++;
          if (it.read_address < FB_BYTES) res.read_data = frame_bytes[it.read_address];
          else res.clipped = 1'b1;
        end
        pfcb_pkg::CMD_CLEAR: begin
          clears++;
          foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        end
        default: unused++;
      endcase
      if (res.clipped) clipped_beats++;
      return res;
    endfunction

    function void note_item(blit_item_t it);
      owed_results.push_back(render_item(it));
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_result(logic [7:0] read_data, logic clipped);
      blit_result_t want;
      if (owed_results.size() == 0) begin
        flag($sformatf("unexpected beat read_data=%02h clipped=%0b", read_data, clipped));
        return;
      end
      want = owed_results.pop_front();
      if (read_data !== want.read_data)
        flag($sformatf("read_data expected %02h got %02h", want.read_data, read_data));
      if (clipped !== want.clipped)
        flag($sformatf("clipped expected %0b got %0b", want.clipped, clipped));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pfcb_in_if  in_ch();
  pfcb_out_if out_ch();

  page_framebuffer_column_blit #(
    .COLUMNS (FB_COLUMNS),
    .PAGES   (FB_PAGES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_scoreboard scoreboard = new();

  bit          sender_idles   = 1'b1;
  bit          receiver_idles = 1'b1;
  bit          hold_done      = 1'b0;
  int unsigned beats_taken    = 0;
  logic [7:0]  last_x         = 8'd0;
  logic [7:0]  last_top       = 8'd0;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic blit_item_t make_item(logic [1:0] command, logic [7:0] x,
                                           logic [7:0] top, logic [7:0] bits,
                                           logic order, logic [1:0] mode,
                                           logic [9:0] addr);
    blit_item_t it;
    it.command      = command;
    it.column_x     = x;
    it.top_row      = top;
    it.column_bits  = bits;
    it.bit_order    = order;
    it.draw_mode    = mode;
    it.read_address = addr;
    return it;
  endfunction

  // Mostly on-panel draws and reads, rare clears, and some full-range noise
  function automatic blit_item_t random_item();
    blit_item_t  it;
    int unsigned pick;
    it.command      = pfcb_pkg::CMD_DRAW;
    it.column_x     = 8'($urandom_range(0, FB_COLUMNS - 1));
    it.top_row      = 8'($urandom_range(0, FB_ROWS - 1));
    it.column_bits  = 8'($urandom_range(0, 255));
    it.bit_order    = 1'($urandom_range(0, 1));
    it.draw_mode    = 2'($urandom_range(0, 2));
    it.read_address = 10'($urandom_range(0, FB_BYTES - 1));
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      last_x   = it.column_x;
      last_top = it.top_row;
    end else if (pick < 60) begin
      // read back a byte touched by a recent draw, either page of it
      it.command      = pfcb_pkg::CMD_READ;
      it.read_address = 10'(((int'(last_top) + $urandom_range(0, 7)) % FB_ROWS / 8)
                            * FB_COLUMNS + last_x);
    end else if (pick < 88) begin
      it.command = pfcb_pkg::CMD_READ;
    end else if (pick < 89) begin
      it.command = pfcb_pkg::CMD_CLEAR;
    end else begin
      it.command      = 2'($urandom_range(0, 3));
      it.column_x     = 8'($urandom_range(0, 255));
      it.top_row      = 8'($urandom_range(0, 255));
      it.draw_mode    = 2'($urandom_range(0, 3));
      it.read_address = 10'($urandom_range(0, 1023));
    end
    return it;
  endfunction

  // Offer one beat, after a random gap in the sender idling phases, and hold it until accepted
  task automatic send_beat(blit_item_t it);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command      = it.command;
    in_ch.column_x     = it.column_x;
    in_ch.top_row      = it.top_row;
    in_ch.column_bits  = it.column_bits;
    in_ch.bit_order    = it.bit_order;
    in_ch.draw_mode    = it.draw_mode;
    in_ch.read_address = it.read_address;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    scoreboard.note_item(it);
  endtask

  // Result side: random stalls in the receiver idling phases, one long hold-off, check every beat
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = receiver_idles ? $urandom_range(0, 3) : 0;
      if (!hold_done && beats_taken >= HOLD_AFTER) begin
        gap       = LONG_HOLD;
        hold_done = 1'b1;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      scoreboard.check_result(out_ch.read_data, out_ch.clipped);
      beats_taken++;
    end
  end

  // Reset, directed items, random phases, drain
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = pfcb_pkg::CMD_DRAW;
    in_ch.column_x     = '0;
    in_ch.top_row      = '0;
    in_ch.column_bits  = '0;
    in_ch.bit_order    = BIT_ORDER_LSB_TOP;
    in_ch.draw_mode    = pfcb_pkg::MODE_OPAQUE;
    in_ch.read_address = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Range edges of reads, straddled pages, each mode, clipping and unused codes
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10'(FB_BYTES - 1)));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10'(FB_BYTES)));
    send_beat(make_item(pfcb_pkg::CMD_READ, 255, 255, 255, pfcb_pkg::BIT_ORDER_MSB_TOP,
                        MODE_UNUSED, 10'h3FF));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 0, 0, 8'hFF, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 10, 3, 8'h81, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OVERLAY, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10'(FB_COLUMNS + 10)));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 10, 5, 8'hFF, pfcb_pkg::BIT_ORDER_MSB_TOP,
                        pfcb_pkg::MODE_ERASE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10'(FB_COLUMNS + 10)));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 0, 4, 8'h0F, pfcb_pkg::BIT_ORDER_MSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 8'(FB_COLUMNS - 1), 8'(FB_ROWS - 4), 8'hA5,
                        pfcb_pkg::BIT_ORDER_MSB_TOP, pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10'(FB_BYTES - 1)));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 8'(FB_COLUMNS), 0, 8'hFF, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 255, 255, 8'hFF, pfcb_pkg::BIT_ORDER_MSB_TOP,
                        pfcb_pkg::MODE_OVERLAY, 10'h3FF));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 20, 0, 8'hFF, BIT_ORDER_LSB_TOP,
                        MODE_UNUSED, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 20));
    send_beat(make_item(CMD_UNUSED, 20, 0, 8'hFF, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 20));
    send_beat(make_item(pfcb_pkg::CMD_DRAW, 50, 8'(FB_ROWS - 8), 8'h5A,
                        pfcb_pkg::BIT_ORDER_MSB_TOP, pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 10'((FB_PAGES - 1) * FB_COLUMNS + 50)));
    send_beat(make_item(pfcb_pkg::CMD_CLEAR, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));
    send_beat(make_item(pfcb_pkg::CMD_READ, 0, 0, 0, BIT_ORDER_LSB_TOP,
                        pfcb_pkg::MODE_OPAQUE, 0));

    // Random part in four idling phases: both, sender only, receiver only, none
    for (int phase = 0; phase < 4; phase++) begin
      sender_idles   = (phase == 0 || phase == 1);
      receiver_idles = (phase == 0 || phase == 2);
      repeat (RANDOM_ITEMS / 4) send_beat(random_item());
    end

    // Drain
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (scoreboard.owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d draws, %0d reads, %0d clears, %0d unused codes; %0d clipped beats.",
             scoreboard.draws, scoreboard.reads, scoreboard.clears, scoreboard.unused,
             scoreboard.clipped_beats);
    $display("Output held off once for %0d cycles; %0d mismatches.", LONG_HOLD,
             scoreboard.mismatches);
    if (scoreboard.mismatches == 0 && scoreboard.owed_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: page_framebuffer_column_blit.f
+incdir+hdl
hdl/pfcb_pkg.sv
hdl/pfcb_if.sv
hdl/pfcb_ram.sv
hdl/pfcb_ctrl.sv
hdl/pfcb_dp.sv
hdl/page_framebuffer_column_blit.sv
sim/testbench.sv
